// ----- rtl/ghist_pkg.sv -----
// Shared constants, types and state codes of the grey-level histogram.
package ghist_pkg;

  localparam int MAX_BINS   = 64;
  localparam int COUNT_BITS = 24;

  localparam int CH_W      = 8;
  localparam int NB_W      = $clog2(MAX_BINS + 1);
  localparam int BIN_W     = $clog2(MAX_BINS);
  localparam int GREY_W    = 15;
  localparam int PROD_W    = GREY_W + NB_W;
  localparam int OUT_CNT_W = 24;

  localparam int W_RED   = 30;
  localparam int W_GREEN = 59;
  localparam int W_BLUE  = 11;

  localparam int GREY_FULL = 25500;

  // floor(p / GREY_FULL) as (p * DIV_MUL) >> DIV_SHIFT, exact for p < 2^PROD_W
  localparam int DIV_SHIFT = 36;
  localparam int DIV_MUL_W = 22;
  localparam logic [63:0] DIV_MUL_L =
    ((64'd1 << DIV_SHIFT) + 64'(GREY_FULL) - 64'd1) / 64'(GREY_FULL);
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_L[DIV_MUL_W-1:0];
  localparam int MULQ_W = PROD_W + DIV_MUL_W;

  localparam logic [NB_W-1:0] NB_RESET = NB_W'(16);

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [BIN_W-1:0]  bin;
    logic [NB_W-1:0]   nb;
  } bin_req_t;

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } sweep_st_e;

endpackage

// ----- rtl/ghist_binner.sv -----
// Pixel-to-bin pipeline: grey weighting, bin scaling, constant division and bin select.
module ghist_binner (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [ghist_pkg::CH_W-1:0]  red_i,
  input  logic [ghist_pkg::CH_W-1:0]  green_i,
  input  logic [ghist_pkg::CH_W-1:0]  blue_i,
  input  logic                        last_i,
  input  logic [ghist_pkg::NB_W-1:0]  nb_i,
  output ghist_pkg::bin_req_t         req_o
);
  import ghist_pkg::*;

  logic                v1_q, v2_q, v3_q, v4_q;
  logic                l1_q, l2_q, l3_q, l4_q;
  logic [NB_W-1:0]     nb1_q, nb2_q, nb3_q, nb4_q;
  logic [GREY_W-1:0]   grey1_q;
  logic [PROD_W-1:0]   prod2_q;
  logic [MULQ_W-1:0]   mul3_q;
  logic [BIN_W-1:0]    bin4_q;

  logic [GREY_W-1:0]   grey_d;
  logic [PROD_W-1:0]   prod_d;
  logic [MULQ_W-1:0]   mul_d;
  logic [NB_W-1:0]     quo;
  logic [BIN_W-1:0]    bin_d;

  always_comb begin
    grey_d = GREY_W'(W_RED) * GREY_W'(red_i) + GREY_W'(W_GREEN) * GREY_W'(green_i)
           + GREY_W'(W_BLUE) * GREY_W'(blue_i);
    prod_d = PROD_W'(grey1_q) * PROD_W'(nb1_q);
    mul_d  = MULQ_W'(prod2_q) * MULQ_W'(DIV_MUL);
    quo    = mul3_q[DIV_SHIFT +: NB_W];
    // full white lands one past the top bin: fold it back
    if (quo >= nb3_q) begin
      bin_d = BIN_W'(nb3_q - NB_W'(1));
    end else begin
      bin_d = BIN_W'(quo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    grey1_q <= grey_d;
    l1_q    <= last_i;
    nb1_q   <= nb_i;
    prod2_q <= prod_d;
    l2_q    <= l1_q;
    nb2_q   <= nb1_q;
    mul3_q  <= mul_d;
    l3_q    <= l2_q;
    nb3_q   <= nb2_q;
    bin4_q  <= bin_d;
    l4_q    <= l3_q;
    nb4_q   <= nb3_q;
  end

  assign req_o.valid = v4_q;
  assign req_o.last  = l4_q;
  assign req_o.bin   = bin4_q;
  assign req_o.nb    = nb4_q;

endmodule

// ----- rtl/ghist_store.sv -----
// Bin count memory: read-modify-write with forwarding, readout and clear sweep.
module ghist_store (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ghist_pkg::bin_req_t              req_i,
  output logic                             sweep_done_o,
  output logic                             res_valid_o,
  output logic [ghist_pkg::BIN_W-1:0]      res_index_o,
  output logic [ghist_pkg::OUT_CNT_W-1:0]  res_count_o,
  output logic                             res_last_o
);
  import ghist_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [BIN_W-1:0]      K_LAST  = BIN_W'(MAX_BINS - 1);

  logic [COUNT_BITS-1:0] mem [MAX_BINS];
  logic [MAX_BINS-1:0]   vld_q;
  logic [COUNT_BITS-1:0] rdata_q;
  logic                  rvld_q;

  sweep_st_e             st_q, st_d;
  logic [BIN_W-1:0]      k_q, k_d;
  logic [NB_W-1:0]       nb_q, nb_d;

  logic                  v5_q, l5_q;
  logic [BIN_W-1:0]      addr5_q;
  logic [NB_W-1:0]       nb5_q;
  logic [NB_W-1:0]       req_nb_hold;
  logic                  fwd_v_q;
  logic [BIN_W-1:0]      fwd_addr_q;
  logic [COUNT_BITS-1:0] fwd_data_q;

  logic                  out_v_q, out_last_q;
  logic [BIN_W-1:0]      out_idx_q;

  logic                  sweep;
  logic [BIN_W-1:0]      raddr;
  logic                  we;
  logic [BIN_W-1:0]      waddr;
  logic [COUNT_BITS-1:0] wdata;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] inc;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (v5_q && l5_q) st_d = ST_SWEEP;
      ST_SWEEP: if (k_q == K_LAST) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    sweep        = 1'b0;
    sweep_done_o = 1'b0;
    k_d          = k_q;
    nb_d         = nb_q;
    case (st_q)
      ST_IDLE: begin
        k_d = '0;
        if (v5_q && l5_q) nb_d = req_nb_hold;
      end
      ST_SWEEP: begin
        sweep        = 1'b1;
        k_d          = k_q + BIN_W'(1);
        sweep_done_o = (k_q == K_LAST);
      end
      default: k_d = '0;
    endcase
  end

  assign req_nb_hold = nb5_q;

  always_comb begin
    if (fwd_v_q && (fwd_addr_q == addr5_q)) begin
      cur = fwd_data_q;
    end else if (rvld_q) begin
      cur = rdata_q;
    end else begin
      cur = '0;
    end
    inc   = (cur == CNT_MAX) ? cur : cur + COUNT_BITS'(1);
    raddr = sweep ? k_q : req_i.bin;
    we    = sweep || v5_q;
    waddr = sweep ? k_q : addr5_q;
    wdata = sweep ? '0 : inc;
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rvld_q   <= 1'b0;
      st_q     <= ST_IDLE;
      k_q      <= '0;
      v5_q     <= 1'b0;
      fwd_v_q  <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      rvld_q  <= vld_q[raddr];
      if (we) vld_q[waddr] <= 1'b1;
      st_q    <= st_d;
      k_q     <= k_d;
      v5_q    <= req_i.valid;
      fwd_v_q <= v5_q && !sweep;
      out_v_q <= sweep && ({1'b0, k_q} < nb_q);
    end
  end

  always_ff @(posedge clk_i) begin
    l5_q       <= req_i.last;
    addr5_q    <= req_i.bin;
    nb5_q      <= req_i.nb;
    nb_q       <= nb_d;
    fwd_addr_q <= addr5_q;
    fwd_data_q <= inc;
    out_idx_q  <= k_q;
    out_last_q <= ({1'b0, k_q} == (nb_q - NB_W'(1)));
  end

  assign res_valid_o = out_v_q;
  assign res_index_o = out_idx_q;
  // an entry never written since reset reads as zero
  assign res_count_o = rvld_q ? OUT_CNT_W'(rdata_q) : '0;
  assign res_last_o  = out_last_q;

endmodule

// ----- rtl/grey_level_histogram.sv -----
// Top level of the grey-level histogram: config register, input gate, binner, store.
//
// One RGB pixel is taken per clock while busy is low, so a full image streams in at
// one pixel per cycle. Each pixel passes a four-stage pipeline (grey weighting,
// scaling by the bin count, constant division, bin select) and then one
// read-modify-write of a count memory with separate read and write ports; a
// write-to-read forwarding register lets back-to-back pixels hit the same bin. An
// item with last_pixel set raises busy at once; the readout sweep starts once that
// pixel has passed the binner pipeline and the store's input register, and the first
// bin comes out in the cycle after that. The sweep walks all 64 memory entries, one
// per cycle, emitting the first num_bins of them and writing zero behind itself.
// busy falls with the sweep, so the last pixel holds the input off until every
// entry is cleared. Results come one per cycle on result_valid_o and cannot be held
// off: the receiver must take every cycle in which the strobe is high. Counters are
// clear after reset without any sweep. Write num_bins only while no image is in
// flight; 0 acts as one bin, above 64 as 64.
module grey_level_histogram (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ghist_pkg::NB_W-1:0]       cfg_wdata_i,
  input  logic                             start,
  output logic                             busy,
  input  logic [ghist_pkg::CH_W-1:0]       red_i,
  input  logic [ghist_pkg::CH_W-1:0]       green_i,
  input  logic [ghist_pkg::CH_W-1:0]       blue_i,
  input  logic                             last_pixel_i,
  output logic                             result_valid_o,
  output logic [ghist_pkg::BIN_W-1:0]      bin_index_o,
  output logic [ghist_pkg::OUT_CNT_W-1:0]  bin_count_o,
  output logic                             last_bin_o
);
  import ghist_pkg::*;

  logic [NB_W-1:0] num_bins_q;
  logic [NB_W-1:0] nb_act;
  logic            busy_q, busy_d;
  logic            accept;
  logic            sweep_done;
  bin_req_t        req;

  // clamp the register into the usable bin range
  always_comb begin
    if (num_bins_q == '0) begin
      nb_act = NB_W'(1);
    end else if (num_bins_q > NB_W'(MAX_BINS)) begin
      nb_act = NB_W'(MAX_BINS);
    end else begin
      nb_act = num_bins_q;
    end
  end

  assign accept = start && !busy_q;

  // hold busy from the last pixel until the clearing sweep ends
  always_comb begin
    busy_d = busy_q;
    if (accept && last_pixel_i) busy_d = 1'b1;
    else if (sweep_done)        busy_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_bins_q <= NB_RESET;
      busy_q     <= 1'b0;
    end else begin
      if (cfg_we_i) num_bins_q <= cfg_wdata_i;
      busy_q <= busy_d;
    end
  end

  assign busy = busy_q;

  ghist_binner u_binner (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .last_i     (last_pixel_i),
    .nb_i       (nb_act),
    .req_o      (req)
  );

  ghist_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .sweep_done_o (sweep_done),
    .res_valid_o  (result_valid_o),
    .res_index_o  (bin_index_o),
    .res_count_o  (bin_count_o),
    .res_last_o   (last_bin_o)
  );

endmodule

// ----- rtl/ghist_checker.sv -----
// Port-level checks of busy and the readout sequence, bound to the top level.
module ghist_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        last_pixel_i,
  input logic                        result_valid_o,
  input logic [ghist_pkg::BIN_W-1:0] bin_index_o,
  input logic                        last_bin_o
);
  import ghist_pkg::*;

  a_busy_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && last_pixel_i |=> busy)
    else $error("busy not raised after last pixel");

  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_o) |-> bin_index_o == '0)
    else $error("readout does not start at bin zero");

  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_bin_o |=> result_valid_o)
    else $error("gap in readout");

  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_bin_o |=>
      bin_index_o == BIN_W'($past(bin_index_o) + BIN_W'(1)))
    else $error("bin index does not advance by one");

  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_bin_o |=> !result_valid_o)
    else $error("result after final bin");

endmodule

bind grey_level_histogram ghist_checker u_ghist_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .last_pixel_i   (last_pixel_i),
  .result_valid_o (result_valid_o),
  .bin_index_o    (bin_index_o),
  .last_bin_o     (last_bin_o)
);

// ----- tb/ghist_readout_checker.sv -----
// Checker for the grey-level histogram: tracks bin counts and compares every readout.
module ghist_readout_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ghist_pkg::NB_W-1:0]      cfg_wdata_i,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic [ghist_pkg::CH_W-1:0]      red_i,
  input  logic [ghist_pkg::CH_W-1:0]      green_i,
  input  logic [ghist_pkg::CH_W-1:0]      blue_i,
  input  logic                            last_pixel_i,
  input  logic                            result_valid_i,
  input  logic [ghist_pkg::BIN_W-1:0]     bin_index_i,
  input  logic [ghist_pkg::OUT_CNT_W-1:0] bin_count_i,
  input  logic                            last_bin_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  import ghist_pkg::*;

  typedef struct packed {
    logic [BIN_W-1:0]     index;
    logic [OUT_CNT_W-1:0] count;
    logic                 last;
  } bin_report_t;

  logic [NB_W-1:0]       bins_setting;
  logic [COUNT_BITS-1:0] pixel_tally [MAX_BINS];
  bin_report_t           due_reports [$];

  // Clamp the register to the bin count actually in use.
  function automatic int unsigned live_bins(input logic [NB_W-1:0] setting);
    if (setting == '0) return 1;
    if (int'(setting) > MAX_BINS) return MAX_BINS;
    return 32'(setting);
  endfunction

  // Bin of a pixel; full white lands in the top bin.
  function automatic logic [BIN_W-1:0] grey_bin(input logic [CH_W-1:0] r,
                                                input logic [CH_W-1:0] g,
                                                input logic [CH_W-1:0] b,
                                                input int unsigned     nbins);
    int unsigned grey;
    int unsigned slot;
    grey = W_RED * int'(r) + W_GREEN * int'(g) + W_BLUE * int'(b);
    slot = (grey * nbins) / GREY_FULL;
    if (slot >= nbins) slot = nbins - 1;
    return slot[BIN_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bin_report_t      want;
    bin_report_t      made;
    logic [BIN_W-1:0] hit;
    int unsigned      nbins;
    if (!rst_ni) begin
      bins_setting = NB_RESET;
      for (int k = 0; k < MAX_BINS; k++) pixel_tally[k] = '0;
      due_reports.delete();
      fail_count_o = 0;
    end else begin
      // Check the report leaving the block at this edge.
      if (result_valid_i) begin
        if (due_reports.size() == 0) begin
          $error("unexpected bin report: index %0d count %0d last %0d",
                 bin_index_i, bin_count_i, last_bin_i);
          fail_count_o++;
        end else begin
          want = due_reports.pop_front();
          if (bin_index_i !== want.index) begin
            $error("bin_index: expected %0d, actual %0d", want.index, bin_index_i);
            fail_count_o++;
          end
          if (bin_count_i !== want.count) begin
            $error("bin_count: expected %0d, actual %0d", want.count, bin_count_i);
            fail_count_o++;
          end
          if (last_bin_i !== want.last) begin
            $error("last_bin: expected %0d, actual %0d", want.last, last_bin_i);
            fail_count_o++;
          end
        end
      end
      // Count an accepted pixel, then queue the readout if it closes the image.
      if (start_i && !busy_i) begin
        nbins = live_bins(bins_setting);
        hit   = grey_bin(red_i, green_i, blue_i, nbins);
        if (pixel_tally[hit] != '1) pixel_tally[hit]++;
        if (last_pixel_i) begin
          for (int k = 0; k < nbins; k++) begin
            made.index = k[BIN_W-1:0];
            made.count = pixel_tally[k][OUT_CNT_W-1:0];
            made.last  = (k + 1 == nbins);
            due_reports.push_back(made);
          end
          for (int k = 0; k < MAX_BINS; k++) pixel_tally[k] = '0;
        end
      end
      if (cfg_we_i) bins_setting = cfg_wdata_i;
    end
    pending_o = due_reports.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Testbench top for the grey-level histogram: clock, reset, pixel stimulus and verdict.
module testbench;

  import ghist_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int DRAIN_CYCLES = 12;      // pixel pipeline plus the store write
  localparam int TAIL_CYCLES  = 80;      // a full 64-entry sweep and some margin
  localparam int RANDOM_ITEMS = 150;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [NB_W-1:0]   cfg_wdata;
  logic              start;
  logic              busy;
  logic [CH_W-1:0]   red;
  logic [CH_W-1:0]   green;
  logic [CH_W-1:0]   blue;
  logic              last_pixel;
  logic              result_valid;
  logic [BIN_W-1:0]  bin_index;
  logic [OUT_CNT_W-1:0] bin_count;
  logic              last_bin;

  int   fail_count;
  int   pending;
  int   cycles;
  logic idle_on;  // when low, the sender streams with no gaps

  grey_level_histogram i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .start          (start),
    .busy           (busy),
    .red_i          (red),
    .green_i        (green),
    .blue_i         (blue),
    .last_pixel_i   (last_pixel),
    .result_valid_o (result_valid),
    .bin_index_o    (bin_index),
    .bin_count_o    (bin_count),
    .last_bin_o     (last_bin)
  );

  ghist_readout_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .start_i        (start),
    .busy_i         (busy),
    .red_i          (red),
    .green_i        (green),
    .blue_i         (blue),
    .last_pixel_i   (last_pixel),
    .result_valid_i (result_valid),
    .bin_index_i    (bin_index),
    .bin_count_i    (bin_count),
    .last_bin_i     (last_bin),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Guard against a hang: stop the run at the cycle limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL grey_level_histogram");
      $finish;
    end
  end

  // Offer one pixel and hold it until accepted. Call and return at a falling edge.
  // busy only moves after a rising edge, so its value here holds through the next
  // rising edge and tells whether the item goes in there.
  task automatic put_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                           input logic [CH_W-1:0] b, input logic last);
    int gap;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start      <= 1'b1;
    red        <= r;
    green      <= g;
    blue       <= b;
    last_pixel <= last;
    while (busy) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Pause the sender until every expected bin has come out and the block is idle,
  // then let the pipeline empty of any pixels still on their way to the store.
  task automatic settle();
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Write the bin count; only ever done with the block idle.
  task automatic write_bins(input logic [NB_W-1:0] setting);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= setting;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int            sent;
    int            len;
    int            split;
    int            style;
    logic [CH_W-1:0] r, g, b;

    rst_ni     = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    start      = 1'b0;
    red        = '0;
    green      = '0;
    blue       = '0;
    last_pixel = 1'b0;
    idle_on    = 1'b1;
    cycles     = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes of each channel under the reset bin count, with gaps.
    put_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    put_pixel(8'd255, 8'd255, 8'd255, 1'b0);  // full white, top bin
    put_pixel(8'd255, 8'd0,   8'd0,   1'b0);
    put_pixel(8'd0,   8'd255, 8'd0,   1'b0);
    put_pixel(8'd0,   8'd0,   8'd255, 1'b0);
    put_pixel(8'd128, 8'd64,  8'd200, 1'b1);

    // Back-to-back for the directed tests below to exercise same-bin forwarding.
    idle_on = 1'b0;
    write_bins(NB_W'(1));
    put_pixel(8'd255, 8'd255, 8'd255, 1'b1);

    write_bins(NB_W'(MAX_BINS));
    put_pixel(8'd1,   8'd1,   8'd1,   1'b0);
    put_pixel(8'd1,   8'd1,   8'd1,   1'b0);
    put_pixel(8'd255, 8'd255, 8'd254, 1'b0);
    put_pixel(8'd254, 8'd255, 8'd255, 1'b1);

    // Zero bins acts as one bin; above the maximum acts as the maximum.
    write_bins(NB_W'(0));
    put_pixel(8'd17,  8'd34,  8'd51,  1'b1);
    write_bins(NB_W'(127));
    put_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    put_pixel(8'd0,   8'd0,   8'd0,   1'b1);

    // Change the bin count in the middle of an image; the readout uses the new count
    // and the bins above it must still come back cleared in the next image.
    write_bins(NB_W'(8));
    put_pixel(8'd200, 8'd10,  8'd30,  1'b0);
    put_pixel(8'd90,  8'd90,  8'd90,  1'b0);
    put_pixel(8'd250, 8'd250, 8'd250, 1'b0);
    write_bins(NB_W'(5));
    put_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    put_pixel(8'd40,  8'd40,  8'd40,  1'b1);
    write_bins(NB_W'(20));
    put_pixel(8'd128, 8'd128, 8'd128, 1'b1);

    // Random images: random lengths, bin counts, content styles and gaps.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 9))
          0:       write_bins(NB_W'(0));
          1:       write_bins(NB_W'(1));
          2:       write_bins(NB_W'(MAX_BINS));
          3:       write_bins(NB_W'($urandom_range(MAX_BINS + 1, 127)));
          default: write_bins(NB_W'($urandom_range(2, MAX_BINS - 1)));
        endcase
      end
      idle_on = ($urandom_range(0, 3) != 0);
      len     = $urandom_range(1, 12);
      if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
      split   = (len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : 0;
      style   = $urandom_range(0, 2);
      r = CH_W'($urandom_range(0, 255));
      g = CH_W'($urandom_range(0, 255));
      b = CH_W'($urandom_range(0, 255));
      for (int i = 0; i < len; i++) begin
        if (split != 0 && i == split) write_bins(NB_W'($urandom_range(1, MAX_BINS)));
        // Style 1 repeats one pixel to hammer one bin; style 2 sticks to channel extremes.
        case (style)
          0: begin
            r = CH_W'($urandom_range(0, 255));
            g = CH_W'($urandom_range(0, 255));
            b = CH_W'($urandom_range(0, 255));
          end
          2: begin
            r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          end
          default: ;
        endcase
        put_pixel(r, g, b, i == len - 1);
        sent++;
      end
      if ($urandom_range(0, 4) == 0) settle();
    end

    // Drain, then watch a while longer for stray reports.
    settle();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (pending != 0) $error("%0d expected bin reports never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS grey_level_histogram");
    end else begin
      $display("FAIL grey_level_histogram");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ghist_pkg.sv
rtl/ghist_binner.sv
rtl/ghist_store.sv
rtl/grey_level_histogram.sv
rtl/ghist_checker.sv
tb/ghist_readout_checker.sv
tb/testbench.sv
